// File: rtl/riot_ram_io_timer_assert.svh
// ----------------------------------------------------------------------------
// riot assertion macros
// shared property forms for the ram-i/o-timer checks
// ----------------------------------------------------------------------------
`ifndef RIOT_RAM_IO_TIMER_ASSERT_SVH
`define RIOT_RAM_IO_TIMER_ASSERT_SVH

// same-cycle implication
`define RIOT_ASSERT_HOLD(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("riot check failed");

// next-cycle implication
`define RIOT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("riot check failed");

`endif

// File: rtl/riot_pkg.sv
// ----------------------------------------------------------------------------
// riot_pkg
// types, codes and constants shared by the ram-i/o-timer modules
// ----------------------------------------------------------------------------
`default_nettype none

package riot_pkg;

    localparam int RAM_BYTES_DEF = 128;
    localparam int TICKS_W       = 18;

    typedef enum logic [2:0] {
        FN_READ     = 3'd0,
        FN_WRITE    = 3'd1,
        FN_EDGE_CTL = 3'd2,
        FN_PINS_A   = 3'd3,
        FN_PINS_B   = 3'd4,
        FN_TICK     = 3'd5
    } func_t;

    localparam logic [7:0] ADDR_PORTA = 8'h00;
    localparam logic [7:0] ADDR_DDRA  = 8'h01;
    localparam logic [7:0] ADDR_PORTB = 8'h02;
    localparam logic [7:0] ADDR_DDRB  = 8'h03;

    localparam logic [3:0] SHIFT_TABLE [4] = '{4'd0, 4'd3, 4'd6, 4'd10};

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] addr;
        logic [7:0] wdata;
        logic [7:0] pin_mask;
    } req_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       irq;
        logic [7:0] porta_out;
        logic [7:0] portb_out;
        logic       porta_written;
        logic       portb_written;
    } rsp_t;

    typedef struct packed {
        logic       load;
        logic       tick;
        logic [1:0] sel;
        logic [7:0] value;
        logic       irq_en;
    } timer_cmd_t;

    typedef struct packed {
        logic [7:0] count;
        logic       flag;
        logic       flag_next;
        logic       irq_en_next;
    } timer_stat_t;

endpackage

`default_nettype wire

// File: rtl/riot_ram.sv
// ----------------------------------------------------------------------------
// riot_ram
// scratch ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module riot_ram
    import riot_pkg::*;
#(
    parameter int RAM_BYTES = RAM_BYTES_DEF,
    parameter int RAM_AW    = $clog2(RAM_BYTES)
)
(
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [RAM_AW-1:0] rd_addr,
    output logic      [7:0]        rd_data,
    input  wire logic              wr_en,
    input  wire logic [RAM_AW-1:0] wr_addr,
    input  wire logic [7:0]        wr_data
);

    logic [7:0] mem [RAM_BYTES];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/riot_timer.sv
// ----------------------------------------------------------------------------
// riot_timer
// interval timer with 1/8/64/1024 prescale and expiry flag
// ----------------------------------------------------------------------------
`default_nettype none

module riot_timer
    import riot_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire timer_cmd_t  cmd,
    output timer_stat_t      stat
);

    logic [1:0]         sel_reg, sel_next;
    logic [TICKS_W-1:0] ticks_left_reg, ticks_left_next;
    logic [7:0]         since_reg, since_next;
    logic               running_reg, running_next;
    logic               flag_reg, flag_next;
    logic               irq_en_reg, irq_en_next;
    logic [TICKS_W-1:0] scaled;

    always_comb
    begin
        sel_next        = sel_reg;
        ticks_left_next = ticks_left_reg;
        since_next      = since_reg;
        running_next    = running_reg;
        flag_next       = flag_reg;
        irq_en_next     = irq_en_reg;
        if (cmd.load)
        begin
            sel_next        = cmd.sel;
            ticks_left_next = TICKS_W'(cmd.value) << SHIFT_TABLE[cmd.sel];
            running_next    = 1'b1;
            flag_next       = 1'b0;
            since_next      = 8'h00;
            irq_en_next     = cmd.irq_en;
        end
        else if (cmd.tick)
        begin
            if (running_reg)
            begin
                if (ticks_left_reg < TICKS_W'(2))
                begin
                    ticks_left_next = '0;
                    running_next    = 1'b0;
                    flag_next       = 1'b1;
                    since_next      = 8'h00;
                end
                else
                begin
                    ticks_left_next = ticks_left_reg - TICKS_W'(1);
                end
            end
            else
            begin
                since_next = since_reg + 8'h01;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg        <= 2'd0;
            ticks_left_reg <= '0;
            since_reg      <= 8'h00;
            running_reg    <= 1'b0;
            flag_reg       <= 1'b0;
            irq_en_reg     <= 1'b0;
        end
        else
        begin
            sel_reg        <= sel_next;
            ticks_left_reg <= ticks_left_next;
            since_reg      <= since_next;
            running_reg    <= running_next;
            flag_reg       <= flag_next;
            irq_en_reg     <= irq_en_next;
        end
    end

    assign scaled = ticks_left_reg >> SHIFT_TABLE[sel_reg];

    always_comb
    begin
        stat.count       = running_reg ? scaled[7:0] : since_reg;
        stat.flag        = flag_reg;
        stat.flag_next   = flag_next;
        stat.irq_en_next = irq_en_next;
    end

endmodule

`default_nettype wire

// File: rtl/riot_ram_io_timer.sv
// ----------------------------------------------------------------------------
// riot_ram_io_timer
// ram, two i/o ports with direction registers, pa7 edge detect, interval timer
// ----------------------------------------------------------------------------
// usage
//   req channel: one transaction per bus read, bus write, edge control write,
//   port pin update or timer tick; rsp channel: one transaction per request,
//   in request order, with read data, irq level and port output registers
//   path: each request passes the ram read register, then the execute stage
//   that updates registers and loads the response register
//   throughput: one request per cycle unless rsp stalls; the ram read of the next
//   request overlaps the execute of the previous one, a write to the same ram byte
//   is forwarded
//   reset: ports, direction registers, flags and timer clear; ram contents
//   are undefined until written, no clearing pass
//   rsp stall: the response register holds, the execute stage holds one
//   more request, after that req_ready drops until rsp_ready returns
// ----------------------------------------------------------------------------
`default_nettype none

module riot_ram_io_timer
    import riot_pkg::*;
#(
    parameter int RAM_BYTES = RAM_BYTES_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    localparam int RAM_AW = $clog2(RAM_BYTES);

    logic        ex_valid_reg, ex_valid_next;
    req_t        ex_req_reg;
    logic        fwd_reg, fwd_next;
    logic [7:0]  fwd_data_reg;
    logic        rsp_valid_reg, rsp_valid_next;
    rsp_t        rsp_reg, rsp_next;

    logic [7:0]  outa_reg, outa_next;
    logic [7:0]  outb_reg, outb_next;
    logic [7:0]  dira_reg, dira_next;
    logic [7:0]  dirb_reg, dirb_next;
    logic [7:0]  pins_a_reg, pins_a_next;
    logic [7:0]  pins_b_reg, pins_b_next;
    logic        last_pa7_reg, last_pa7_next;
    logic        edge_pos_reg, edge_pos_next;
    logic        edge_irq_en_reg, edge_irq_en_next;
    logic        edge_flag_reg, edge_flag_next;

    logic        ex_go, req_acc;
    logic        is_read, is_write, is_pins_a, is_pins_b;
    logic        is_ram, ram_hit, is_timer_area, edge_chk, pa7_lvl;
    logic        req_ram_hit;
    logic [7:0]  ram_rd_data, ram_byte, porta_lvl, portb_lvl, rd_val;
    timer_cmd_t  tcmd;
    timer_stat_t tstat;

    assign ex_go     = ex_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !ex_valid_reg || ex_go;
    assign req_acc   = req_valid && req_ready;

    assign is_read       = ex_req_reg.func == FN_READ;
    assign is_write      = ex_req_reg.func == FN_WRITE;
    assign is_pins_a     = ex_req_reg.func == FN_PINS_A;
    assign is_pins_b     = ex_req_reg.func == FN_PINS_B;
    assign is_ram        = ex_req_reg.addr[7];
    assign ram_hit       = is_ram && ({1'b0, ex_req_reg.addr[6:0]} < 8'(RAM_BYTES));
    assign is_timer_area = !is_ram && (ex_req_reg.addr[6:2] != 5'd0);
    assign req_ram_hit   = req.addr[7] && ({1'b0, req.addr[6:0]} < 8'(RAM_BYTES));

    riot_ram #(
        .RAM_BYTES (RAM_BYTES),
        .RAM_AW    (RAM_AW)
    ) u_ram (
        .clk     (clk),
        .rd_en   (req_acc),
        .rd_addr (req.addr[RAM_AW-1:0]),
        .rd_data (ram_rd_data),
        .wr_en   (ex_go && is_write && ram_hit),
        .wr_addr (ex_req_reg.addr[RAM_AW-1:0]),
        .wr_data (ex_req_reg.wdata)
    );

    // same-byte write in the execute stage overtakes the ram read
    assign fwd_next = ex_go && is_write && ram_hit && req_ram_hit
                      && (ex_req_reg.addr == req.addr);
    assign ram_byte = fwd_reg ? fwd_data_reg : ram_rd_data;

    always_comb
    begin
        tcmd.load   = ex_go && is_write && is_timer_area;
        tcmd.tick   = ex_go && (ex_req_reg.func == FN_TICK);
        tcmd.sel    = ex_req_reg.addr[1:0];
        tcmd.value  = ex_req_reg.wdata;
        tcmd.irq_en = ex_req_reg.addr[3];
    end

    riot_timer u_timer (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (tcmd),
        .stat  (tstat)
    );

    assign porta_lvl = (outa_reg & dira_reg) | (pins_a_reg & ~dira_reg);
    assign portb_lvl = (outb_reg & dirb_reg) | (pins_b_reg & ~dirb_reg);

    always_comb
    begin
        if (is_ram)
        begin
            rd_val = ram_hit ? ram_byte : 8'h00;
        end
        else
        begin
            case (ex_req_reg.addr)
                ADDR_PORTA: rd_val = porta_lvl;
                ADDR_DDRA:  rd_val = dira_reg;
                ADDR_PORTB: rd_val = portb_lvl;
                ADDR_DDRB:  rd_val = dirb_reg;
                default:
                begin
                    if (ex_req_reg.addr[0])
                    begin
                        rd_val = {tstat.flag, edge_flag_reg, 6'b000000};
                    end
                    else
                    begin
                        rd_val = tstat.count;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        outa_next        = outa_reg;
        outb_next        = outb_reg;
        dira_next        = dira_reg;
        dirb_next        = dirb_reg;
        pins_a_next      = pins_a_reg;
        pins_b_next      = pins_b_reg;
        edge_pos_next    = edge_pos_reg;
        edge_irq_en_next = edge_irq_en_reg;
        if (ex_go)
        begin
            if (is_write)
            begin
                case (ex_req_reg.addr)
                    ADDR_PORTA: outa_next = ex_req_reg.wdata;
                    ADDR_DDRA:  dira_next = ex_req_reg.wdata;
                    ADDR_PORTB: outb_next = ex_req_reg.wdata;
                    ADDR_DDRB:  dirb_next = ex_req_reg.wdata;
                    default:    outa_next = outa_reg;
                endcase
            end
            if (is_pins_a)
            begin
                pins_a_next = (pins_a_reg & ~ex_req_reg.pin_mask)
                              | (ex_req_reg.wdata & ex_req_reg.pin_mask);
            end
            if (is_pins_b)
            begin
                pins_b_next = (pins_b_reg & ~ex_req_reg.pin_mask)
                              | (ex_req_reg.wdata & ex_req_reg.pin_mask);
            end
            if (ex_req_reg.func == FN_EDGE_CTL)
            begin
                edge_pos_next    = ex_req_reg.wdata[0];
                edge_irq_en_next = ex_req_reg.wdata[1];
            end
        end
    end

    assign edge_chk = ex_go && ((is_write && ((ex_req_reg.addr == ADDR_PORTA)
                                             || (ex_req_reg.addr == ADDR_DDRA)))
                                || is_pins_a);
    assign pa7_lvl  = (outa_next[7] & dira_next[7]) | (pins_a_next[7] & ~dira_next[7]);

    always_comb
    begin
        last_pa7_next  = edge_chk ? pa7_lvl : last_pa7_reg;
        edge_flag_next = edge_flag_reg;
        if (ex_go && is_read && is_timer_area && ex_req_reg.addr[0])
        begin
            edge_flag_next = 1'b0;
        end
        else if (edge_chk && (pa7_lvl != last_pa7_reg) && (pa7_lvl == edge_pos_reg))
        begin
            edge_flag_next = 1'b1;
        end
    end

    always_comb
    begin
        rsp_next.rdata         = is_read ? rd_val : 8'h00;
        rsp_next.irq           = (tstat.irq_en_next & tstat.flag_next)
                                 | (edge_irq_en_next & edge_flag_next);
        rsp_next.porta_out     = outa_next;
        rsp_next.portb_out     = outb_next;
        rsp_next.porta_written = is_write && (ex_req_reg.addr == ADDR_PORTA);
        rsp_next.portb_written = is_write && (ex_req_reg.addr == ADDR_PORTB);
    end

    assign ex_valid_next  = req_acc ? 1'b1 : (ex_go ? 1'b0 : ex_valid_reg);
    assign rsp_valid_next = ex_go ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg    <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            outa_reg        <= 8'h00;
            outb_reg        <= 8'h00;
            dira_reg        <= 8'h00;
            dirb_reg        <= 8'h00;
            pins_a_reg      <= 8'h00;
            pins_b_reg      <= 8'h00;
            last_pa7_reg    <= 1'b0;
            edge_pos_reg    <= 1'b0;
            edge_irq_en_reg <= 1'b0;
            edge_flag_reg   <= 1'b0;
        end
        else
        begin
            ex_valid_reg    <= ex_valid_next;
            rsp_valid_reg   <= rsp_valid_next;
            outa_reg        <= outa_next;
            outb_reg        <= outb_next;
            dira_reg        <= dira_next;
            dirb_reg        <= dirb_next;
            pins_a_reg      <= pins_a_next;
            pins_b_reg      <= pins_b_next;
            last_pa7_reg    <= last_pa7_next;
            edge_pos_reg    <= edge_pos_next;
            edge_irq_en_reg <= edge_irq_en_next;
            edge_flag_reg   <= edge_flag_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            ex_req_reg   <= req;
            fwd_reg      <= fwd_next;
            fwd_data_reg <= ex_req_reg.wdata;
        end
        if (ex_go)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// File: rtl/riot_ram_io_timer_checker.sv
// ----------------------------------------------------------------------------
// riot_ram_io_timer_checker
// port-level checks on the ram-i/o-timer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "riot_ram_io_timer_assert.svh"

module riot_ram_io_timer_checker
    import riot_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    input  wire logic req_ready,
    input  wire logic rsp_valid,
    input  wire logic rsp_ready,
    input  wire rsp_t rsp
);

    // stalled response holds
    `RIOT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

    // one transaction writes at most one port
    `RIOT_ASSERT_HOLD(a_one_port, rsp_valid, !(rsp.porta_written && rsp.portb_written))

    // writes return no read data
    `RIOT_ASSERT_HOLD(a_wr_rdata, rsp_valid && (rsp.porta_written || rsp.portb_written),
                      rsp.rdata == 8'h00)

    // with the response stalled, a new request fills the execute stage
    `RIOT_ASSERT_NEXT(a_fill, rsp_valid && !rsp_ready && req_valid && req_ready,
                      req_ready == rsp_ready)

endmodule

bind riot_ram_io_timer riot_ram_io_timer_checker u_checker (.*);

`default_nettype wire
